// ===== hw/rtl/ssl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stick slew limiter package
// Shared widths, register indexes and the request bundle for the divider lanes.
// ----------------------------------------------------------------------------
package ssl_pkg;

  localparam int LEVEL_W = 16;
  localparam int SUM_W   = 17;
  localparam int STEP_W  = 15;
  localparam int CFG_W   = 2;

  localparam logic [STEP_W-1:0] SLEW_STEP_RST = 15'd2185;

  typedef enum logic [CFG_W-1:0] {
    CFG_ENABLE     = 2'd0,
    CFG_DRIVE_MODE = 2'd1,
    CFG_SLEW_STEP  = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic             start;
    logic             neg;
    logic [SUM_W-1:0] num;
    logic [SUM_W-1:0] den;
  } div_req_t;

endpackage : ssl_pkg
`default_nettype wire

// ===== hw/rtl/ssl_slew_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Slew lane
// Holds one smoothed axis and moves it toward its target by at most one step.
// ----------------------------------------------------------------------------
module ssl_slew_lane (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 load,
  input  wire logic signed [ssl_pkg::LEVEL_W-1:0]   target,
  input  wire logic        [ssl_pkg::STEP_W-1:0]    step,
  output      logic signed [ssl_pkg::LEVEL_W-1:0]   level
);

  logic signed [ssl_pkg::LEVEL_W-1:0] level_r, level_nxt;
  logic signed [ssl_pkg::SUM_W-1:0]   diff, lim, pos, negs;

  always_comb begin
    diff = ssl_pkg::SUM_W'(target) - ssl_pkg::SUM_W'(level_r);
    pos  = $signed({2'b00, step});
    negs = -pos;
    if (diff > pos) begin
      lim = pos;
    end else if (diff < negs) begin
      lim = negs;
    end else begin
      lim = diff;
    end
    level_nxt = ssl_pkg::LEVEL_W'(ssl_pkg::SUM_W'(level_r) + lim);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
    end else if (load) begin
      level_r <= level_nxt;
    end
  end

  assign level = level_r;

endmodule : ssl_slew_lane
`default_nettype wire

// ===== hw/rtl/ssl_div_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Divider lane
// Restoring divider that scales one tank value by full stick over the peak.
// ----------------------------------------------------------------------------
module ssl_div_lane #(
  parameter int FRAC_BITS = 14
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire ssl_pkg::div_req_t                  req,
  output      logic                               busy,
  output      logic signed [ssl_pkg::LEVEL_W-1:0] quo
);

  localparam int QB  = FRAC_BITS + 1;
  localparam int CNT_W = $clog2(QB + 1);
  localparam int QW  = (FRAC_BITS + 2 > ssl_pkg::LEVEL_W) ? FRAC_BITS + 2 : ssl_pkg::LEVEL_W;
  localparam int RW  = ssl_pkg::SUM_W + 1;

  logic                         busy_r, busy_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic [RW-1:0]                rem_r, rem_nxt;
  logic [ssl_pkg::SUM_W-1:0]    den_r;
  logic                         neg_r;
  logic [QB-1:0]                q_r, q_nxt;
  logic [RW-1:0]                den_x, diff;
  logic                         ge;
  logic signed [QW-1:0]         qmag, qs;

  always_comb begin
    den_x    = RW'(den_r);
    ge       = (rem_r >= den_x);
    diff     = ge ? (rem_r - den_x) : rem_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (req.start) begin
      rem_nxt  = RW'(req.num);
      q_nxt    = '0;
      cnt_nxt  = CNT_W'(QB);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = {diff[RW-2:0], 1'b0};
      q_nxt   = {q_r[QB-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    if (req.start) begin
      den_r <= req.den;
      neg_r <= req.neg;
    end
  end

  always_comb begin
    qmag = $signed(QW'(q_r));
    qs   = neg_r ? -qmag : qmag;
  end

  assign busy = busy_r;
  assign quo  = qs[ssl_pkg::LEVEL_W-1:0];

endmodule : ssl_div_lane
`default_nettype wire

// ===== hw/rtl/stick_slew_limit_drive_mixer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stick slew limiter with tank drive mixing
// Three slew lanes smooth the stick axes, two divider lanes normalize the
// tank pair, and the merge stage assembles one result per enabled request.
//
//   Channel | Direction | Handshake          | Payload
//   in      | input     | in_valid/in_ready  | forward, strafe, rotate targets
//   out     | output    | out_valid/out_ready| smoothed axes, tank pair, mode
//   cfg     | input     | cfg_we             | cfg_index, cfg_wdata
//
// A request passes through S_MIX, S_NORM and S_DONE without normalization, and
// also through S_DIV when the tank pair must be scaled; the divider lanes
// produce one quotient bit per cycle.
// Reset is synchronous and restores the configuration registers and clears the axes.
// A finished result waits in the output register while the next request is
// taken; the core stalls only when that register is still full.
// ----------------------------------------------------------------------------
module stick_slew_limit_drive_mixer_top #(
  parameter int FRAC_BITS = 14
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output      logic                                in_ready,
  input  wire logic signed [ssl_pkg::LEVEL_W-1:0]  in_forward_target,
  input  wire logic signed [ssl_pkg::LEVEL_W-1:0]  in_strafe_target,
  input  wire logic signed [ssl_pkg::LEVEL_W-1:0]  in_rotate_target,
  output      logic                                out_valid,
  input  wire logic                                out_ready,
  output      logic signed [ssl_pkg::LEVEL_W-1:0]  out_smooth_forward,
  output      logic signed [ssl_pkg::LEVEL_W-1:0]  out_smooth_strafe,
  output      logic signed [ssl_pkg::LEVEL_W-1:0]  out_smooth_rotate,
  output      logic signed [ssl_pkg::LEVEL_W-1:0]  out_tank_left,
  output      logic signed [ssl_pkg::LEVEL_W-1:0]  out_tank_right,
  output      logic                                out_tank_selected,
  input  wire logic                                cfg_we,
  input  wire logic [ssl_pkg::CFG_W-1:0]           cfg_index,
  input  wire logic [ssl_pkg::STEP_W-1:0]          cfg_wdata
);

  localparam int CW = (FRAC_BITS + 2 > ssl_pkg::SUM_W + 1) ? FRAC_BITS + 2 : ssl_pkg::SUM_W + 1;
  localparam logic [CW-1:0] FULL = CW'(1) << FRAC_BITS;
  localparam int SW = ssl_pkg::SUM_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MIX  = 5'b00010,
    S_NORM = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic                        enable_r, drive_mode_r;
  logic [ssl_pkg::STEP_W-1:0]  slew_step_r;

  logic                        load;
  logic signed [ssl_pkg::LEVEL_W-1:0] lvl_f, lvl_s, lvl_r;

  logic signed [SW-1:0]        left_r, right_r, left_c, right_c;
  logic [SW-1:0]               abs_l, abs_r, mag;
  logic                        need_div;
  logic                        div_used_r, div_used_nxt;
  ssl_pkg::div_req_t           req_l, req_r;
  logic                        busy_l, busy_r;
  logic signed [ssl_pkg::LEVEL_W-1:0] quo_l, quo_r;

  logic                        out_load;
  logic                        out_valid_r, out_valid_nxt;
  logic signed [ssl_pkg::LEVEL_W-1:0] res_f_r, res_s_r, res_rot_r, res_l_r, res_r_r;
  logic                        res_mode_r;

  assign in_ready = (state_r == S_IDLE);
  assign load     = in_valid && in_ready && enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= 1'b0;
      drive_mode_r <= 1'b0;
      slew_step_r  <= ssl_pkg::SLEW_STEP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ssl_pkg::CFG_ENABLE:     enable_r     <= cfg_wdata[0];
        ssl_pkg::CFG_DRIVE_MODE: drive_mode_r <= cfg_wdata[0];
        ssl_pkg::CFG_SLEW_STEP:  slew_step_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  ssl_slew_lane u_lane_fwd (
    .clk(clk), .rst_n(rst_n), .load(load),
    .target(in_forward_target), .step(slew_step_r), .level(lvl_f)
  );

  ssl_slew_lane u_lane_str (
    .clk(clk), .rst_n(rst_n), .load(load),
    .target(in_strafe_target), .step(slew_step_r), .level(lvl_s)
  );

  ssl_slew_lane u_lane_rot (
    .clk(clk), .rst_n(rst_n), .load(load),
    .target(in_rotate_target), .step(slew_step_r), .level(lvl_r)
  );

  always_comb begin
    left_c   = SW'(lvl_f) + SW'(lvl_r);
    right_c  = SW'(lvl_f) - SW'(lvl_r);
    abs_l    = left_r[SW-1]  ? SW'(-left_r)  : SW'(left_r);
    abs_r    = right_r[SW-1] ? SW'(-right_r) : SW'(right_r);
    mag      = (abs_l > abs_r) ? abs_l : abs_r;
    need_div = (CW'(mag) > FULL);
  end

  always_ff @(posedge clk) begin
    if (state_r == S_MIX) begin
      left_r  <= left_c;
      right_r <= right_c;
    end
  end

  always_comb begin
    req_l.start = (state_r == S_NORM) && need_div;
    req_l.neg   = left_r[SW-1];
    req_l.num   = abs_l;
    req_l.den   = mag;
    req_r.start = req_l.start;
    req_r.neg   = right_r[SW-1];
    req_r.num   = abs_r;
    req_r.den   = mag;
  end

  ssl_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div_left (
    .clk(clk), .rst_n(rst_n), .req(req_l), .busy(busy_l), .quo(quo_l)
  );

  ssl_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div_right (
    .clk(clk), .rst_n(rst_n), .req(req_r), .busy(busy_r), .quo(quo_r)
  );

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt    = state_r;
    div_used_nxt = div_used_r;
    case (state_r)
      S_IDLE: begin
        if (load) begin
          state_nxt = S_MIX;
        end
      end
      S_MIX: begin
        state_nxt = S_NORM;
      end
      S_NORM: begin
        div_used_nxt = need_div;
        state_nxt    = need_div ? S_DIV : S_DONE;
      end
      S_DIV: begin
        if (!busy_l && !busy_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_used_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_used_r  <= div_used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_f_r    <= lvl_f;
      res_s_r    <= lvl_s;
      res_rot_r  <= lvl_r;
      res_l_r    <= div_used_r ? quo_l : left_r[ssl_pkg::LEVEL_W-1:0];
      res_r_r    <= div_used_r ? quo_r : right_r[ssl_pkg::LEVEL_W-1:0];
      res_mode_r <= drive_mode_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_smooth_forward = res_f_r;
  assign out_smooth_strafe  = res_s_r;
  assign out_smooth_rotate  = res_rot_r;
  assign out_tank_left      = res_l_r;
  assign out_tank_right     = res_r_r;
  assign out_tank_selected  = res_mode_r;

endmodule : stick_slew_limit_drive_mixer_top
`default_nettype wire
